@@ design/cts_pkg.sv @@
// ----------------------------------------------------------------------------
// cts_pkg - cooperative task scheduler shared definitions
// Request/response payload types, the slot-chain token, status and op codes.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int MAX_OUT       = 8;   // results per dispatch pass
  localparam int CNT_W         = $clog2(MAX_OUT + 1);
  localparam int OUT_SLOT_W    = 7;
  localparam int SLOT_W        = 6;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_DELETE   = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_DISPATCH = 2'd3;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_DELETED = 3'd2;
  localparam logic [2:0] ST_BAD     = 3'd3;
  localparam logic [2:0] ST_TICKED  = 3'd4;
  localparam logic [2:0] ST_RUN     = 3'd5;
  localparam logic [2:0] ST_NONE    = 3'd6;

  localparam logic [OUT_SLOT_W-1:0] FULL_SLOT = 7'd64;

  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        task_tag;
    logic [15:0]       first_delay;
    logic [15:0]       repeat_period;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [OUT_SLOT_W-1:0] out_slot;
    logic [7:0]            run_tag;
    logic                  last;
  } rsp_t;

  // token walking the slot chain
  typedef struct packed {
    logic             valid;
    logic             found;  // add: a free slot was already claimed
    logic [CNT_W-1:0] cnt;    // dispatch: results so far
  } tok_t;

  // per-cell report while the token sits at that cell
  typedef struct packed {
    logic       hit;
    logic [7:0] tag;
  } ev_t;

endpackage

@@ design/cts_cell.sv @@
// ----------------------------------------------------------------------------
// cts_cell - one task slot of the scheduler chain
// Holds one slot's state, acts on the request when the token is at its input,
// and registers the token for the next cell.
// ----------------------------------------------------------------------------
module cts_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  cts_pkg::req_t cmd,
  input  cts_pkg::tok_t tok_i,
  output cts_pkg::tok_t tok_o,
  output cts_pkg::ev_t  ev
);

  logic        used,  used_next;
  logic [7:0]  tag,   tag_next;
  logic [15:0] cd,    cd_next;
  logic [15:0] per,   per_next;
  logic [7:0]  pend,  pend_next;
  cts_pkg::tok_t tok_next;
  logic add_hit, disp_hit;

  assign add_hit  = tok_i.valid && cmd.op == cts_pkg::OP_ADD && !tok_i.found && !used;
  assign disp_hit = tok_i.valid && cmd.op == cts_pkg::OP_DISPATCH && used &&
                    pend != 8'd0 && tok_i.cnt < cts_pkg::CNT_W'(cts_pkg::MAX_OUT);

  assign ev.hit = add_hit || disp_hit;
  assign ev.tag = tag;

  always_comb begin
    used_next = used;
    tag_next  = tag;
    cd_next   = cd;
    per_next  = per;
    pend_next = pend;
    tok_next  = tok_i;
    if (tok_i.valid) begin
      unique case (cmd.op)
        cts_pkg::OP_ADD: begin
          if (add_hit) begin
            used_next = 1'b1;
            tag_next  = cmd.task_tag;
            cd_next   = cmd.first_delay;
            per_next  = cmd.repeat_period;
            pend_next = 8'd0;
            tok_next.found = 1'b1;
          end
        end
        cts_pkg::OP_DELETE: begin
          if (cmd.slot == cts_pkg::SLOT_W'(IDX)) begin
            used_next = 1'b0;
            tag_next  = 8'd0;
            cd_next   = 16'd0;
            per_next  = 16'd0;
            pend_next = 8'd0;
          end
        end
        cts_pkg::OP_TICK: begin
          if (used) begin
            if (cd == 16'd0) begin
              if (pend != 8'hFF) pend_next = pend + 8'd1;
              if (per != 16'd0) cd_next = per - 16'd1;
            end else begin
              cd_next = cd - 16'd1;
            end
          end
        end
        cts_pkg::OP_DISPATCH: begin
          if (disp_hit) begin
            tok_next.cnt = tok_i.cnt + cts_pkg::CNT_W'(1);
            if (per == 16'd0) begin
              // one-shot task leaves the table
              used_next = 1'b0;
              tag_next  = 8'd0;
              cd_next   = 16'd0;
              pend_next = 8'd0;
            end else begin
              pend_next = pend - 8'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= 1'b0;
      tag   <= 8'd0;
      cd    <= 16'd0;
      per   <= 16'd0;
      pend  <= 8'd0;
      tok_o <= '0;
    end else if (step) begin
      used  <= used_next;
      tag   <= tag_next;
      cd    <= cd_next;
      per   <= per_next;
      pend  <= pend_next;
      tok_o <= tok_next;
    end
  end

endmodule

@@ design/cooperative_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// cooperative_task_scheduler - time-triggered cooperative task scheduler
// Task table as a row of slot cells; each request walks the row as a token.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------
//  req     | in  | req_valid/stall   | op, task_tag, first_delay, period, slot
//  rsp     | out | rsp_valid/stall   | status, out_slot, run_tag, last
//
//  A request's token visits one slot cell per cycle while the walk is not
//  stalled, and the closing response is registered once the token leaves
//  the last cell. req_stall drops with that response. Reset (rst,
//  synchronous) clears every slot and drops all handshake state. A stalled
//  rsp freezes the walk only when a dispatch result needs the output
//  register; other requests keep walking and wait at the end.
// ----------------------------------------------------------------------------
module cooperative_task_scheduler #(
  parameter int NUM_SLOTS = cts_pkg::NUM_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cts_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output cts_pkg::rsp_t rsp
);

  // request in flight
  logic          busy;
  logic          start_v;
  cts_pkg::req_t cmd;
  logic [cts_pkg::OUT_SLOT_W-1:0] pos;       // cell holding the token
  logic [cts_pkg::OUT_SLOT_W-1:0] add_slot;

  // dispatch result held back until we know whether it is the final one
  logic                           hold_v;
  logic [cts_pkg::OUT_SLOT_W-1:0] hold_slot;
  logic [7:0]                     hold_tag;

  cts_pkg::tok_t tok [NUM_SLOTS+1];
  cts_pkg::ev_t  ev  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] tok_live;

  logic       hit_any;
  logic [7:0] hit_tag;
  logic       out_free, is_disp, disp_hit, at_end, step;
  cts_pkg::rsp_t fin_rsp;

  assign req_stall = busy;
  assign tok[0]    = '{valid: start_v, found: 1'b0, cnt: '0};

  genvar k;
  generate
    for (k = 0; k < NUM_SLOTS; k++) begin : g_cell
      cts_cell #(.IDX(k)) u_cell (
        .clk  (clk),
        .rst  (rst),
        .step (step),
        .cmd  (cmd),
        .tok_i(tok[k]),
        .tok_o(tok[k+1]),
        .ev   (ev[k])
      );
      assign tok_live[k] = tok[k+1].valid;
    end
  endgenerate

  // only the cell holding the token can report
  always_comb begin
    hit_any = 1'b0;
    hit_tag = 8'd0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit_any = hit_any | ev[i].hit;
      hit_tag = hit_tag | (ev[i].tag & {8{ev[i].hit}});
    end
  end

  assign out_free = !rsp_valid || !rsp_stall;
  assign is_disp  = cmd.op == cts_pkg::OP_DISPATCH;
  assign disp_hit = hit_any && is_disp;
  assign at_end   = tok[NUM_SLOTS].valid;
  // a dispatch hit with a held result pushes that result out
  assign step     = busy && (at_end ? out_free : !(disp_hit && hold_v && !out_free));

  // closing response of the request
  always_comb begin
    fin_rsp = '0;
    fin_rsp.last = 1'b1;
    unique case (cmd.op)
      cts_pkg::OP_ADD: begin
        if (tok[NUM_SLOTS].found) begin
          fin_rsp.status   = cts_pkg::ST_ADDED;
          fin_rsp.out_slot = add_slot;
        end else begin
          fin_rsp.status   = cts_pkg::ST_FULL;
          fin_rsp.out_slot = cts_pkg::FULL_SLOT;
        end
      end
      cts_pkg::OP_DELETE: begin
        fin_rsp.out_slot = {1'b0, cmd.slot};
        fin_rsp.status   = ({1'b0, cmd.slot} < cts_pkg::OUT_SLOT_W'(NUM_SLOTS)) ?
                           cts_pkg::ST_DELETED : cts_pkg::ST_BAD;
      end
      cts_pkg::OP_TICK: begin
        fin_rsp.status = cts_pkg::ST_TICKED;
      end
      cts_pkg::OP_DISPATCH: begin
        if (hold_v) begin
          fin_rsp.status   = cts_pkg::ST_RUN;
          fin_rsp.out_slot = hold_slot;
          fin_rsp.run_tag  = hold_tag;
        end else begin
          fin_rsp.status = cts_pkg::ST_NONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      start_v   <= 1'b0;
      rsp_valid <= 1'b0;
      hold_v    <= 1'b0;
      pos       <= '0;
    end else begin
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      if (req_valid && !busy) begin
        busy    <= 1'b1;
        start_v <= 1'b1;
        cmd     <= req;
        pos     <= '0;
      end
      if (step) begin
        start_v <= 1'b0;
        pos     <= pos + cts_pkg::OUT_SLOT_W'(1);
        if (disp_hit) begin
          if (hold_v) begin
            rsp       <= '{status: cts_pkg::ST_RUN, out_slot: hold_slot,
                           run_tag: hold_tag, last: 1'b0};
            rsp_valid <= 1'b1;
          end
          hold_v    <= 1'b1;
          hold_slot <= pos;
          hold_tag  <= hit_tag;
        end
        if (hit_any && !is_disp) add_slot <= pos;
        if (at_end) begin
          rsp       <= fin_rsp;
          rsp_valid <= 1'b1;
          hold_v    <= 1'b0;
          busy      <= 1'b0;
        end
      end
    end
  end

  // single token in the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    ($countones(tok_live) + 32'(start_v)) <= 1)
    else $error("more than one token in slot chain");

  // held result only during a dispatch walk
  a_hold_disp: assert property (@(posedge clk) disable iff (rst)
    hold_v |-> (busy && is_disp))
    else $error("held result outside dispatch");

  // token position tracks the walk counter
  a_pos: assert property (@(posedge clk) disable iff (rst)
    at_end |-> (pos == cts_pkg::OUT_SLOT_W'(NUM_SLOTS)))
    else $error("walk counter out of step with token");

  // no walk activity while idle
  a_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (!start_v && tok_live == '0))
    else $error("token alive while idle");

endmodule
